// ----- rtl/lsi_pkg.sv -----
// shared constants, types and helpers for the linear step interpolator
`timescale 1ns / 1ps

package lsi_pkg;

  // coordinate handling
  localparam int COORD_WIDTH = 24;            // coordinate bits taken from each field (at most FieldW)
  localparam int FieldW      = 24;            // width of each coordinate field on the bus
  localparam int ExtW        = 32;            // widest coordinate the extender handles
  localparam int DeltaW      = COORD_WIDTH + 1;

  // scaling and step arithmetic
  localparam int SpmW   = 10;
  localparam int MagW   = COORD_WIDTH;
  localparam int ProdW  = MagW + SpmW;
  localparam int SpanW  = ProdW - 8;
  localparam int StepsW = SpanW + 1;
  localparam int DevW   = SpanW + 1;

  localparam logic [SpmW-1:0] SpmReset = SpmW'(80);

  // bus widths
  localparam int InDataW  = 4 * FieldW;
  localparam int OutDataW = 8;

  // configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = SpmW;
  localparam logic [CfgIdxW-1:0] CfgXSpm = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgYSpm = CfgIdxW'(1);

  // output codes
  localparam logic AxisX = 1'b0;
  localparam logic AxisY = 1'b1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // sign-extend the low COORD_WIDTH bits of a field to the delta width
  function automatic logic signed [DeltaW-1:0] coord_ext(input logic [FieldW-1:0] f);
    logic [ExtW-1:0]        z;
    logic [COORD_WIDTH-1:0] c;
    z = ExtW'(f);
    c = z[COORD_WIDTH-1:0];
    return {c[COORD_WIDTH-1], c};
  endfunction

endpackage

// ----- rtl/linear_step_interpolator.sv -----
// two-axis point-by-point linear step interpolator, top level
// a tick accepted on the slave side is held in the input stage register, then its step in the result register
// throughput: one word per cycle unless the master side stalls; one deviation add/subtract per tick
// the endpoint multiply sits in the state stage, the axis deltas in the input stage
// reset: rst_ni async low, clears the move state and sets both steps-per-mm to 80
// no clearing pass after reset, the block takes words at once
`timescale 1ns / 1ps

module linear_step_interpolator
  import lsi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // start_x, start_y, end_x, end_y
  input  logic                s_axis_tuser_i,   // operation
  // master side
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // step_axis, step_dir, zero fill
  output logic                m_axis_tlast_o,   // last
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SpmW-1:0] spm_x_q, spm_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_x_q <= SpmReset;
      spm_y_q <= SpmReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgXSpm: spm_x_q <= cfg_data_i;
        CfgYSpm: spm_y_q <= cfg_data_i;
        default: ;  // unknown register, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input stage: axis deltas reduced to sign and magnitude
  // ---------------------------------------------------------------------------
  logic [FieldW-1:0]        in_sx, in_sy, in_ex, in_ey;
  logic signed [DeltaW-1:0] dx, dy, dx_neg, dy_neg;
  logic [MagW-1:0]          mag_x, mag_y;

  assign in_sx = s_axis_tdata_i[FieldW-1:0];
  assign in_sy = s_axis_tdata_i[2*FieldW-1:FieldW];
  assign in_ex = s_axis_tdata_i[3*FieldW-1:2*FieldW];
  assign in_ey = s_axis_tdata_i[4*FieldW-1:3*FieldW];

  assign dx     = coord_ext(in_ex) - coord_ext(in_sx);
  assign dy     = coord_ext(in_ey) - coord_ext(in_sy);
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  // magnitude never needs the sign bit: |delta| stays below 2^COORD_WIDTH
  assign mag_x  = dx[DeltaW-1] ? dx_neg[MagW-1:0] : dx[MagW-1:0];
  assign mag_y  = dy[DeltaW-1] ? dy_neg[MagW-1:0] : dy[MagW-1:0];

  logic            s1_v_q;
  op_e             s1_op_q;
  logic [MagW-1:0] s1_mag_x_q, s1_mag_y_q;
  logic            s1_neg_x_q, s1_neg_y_q;

  // ---------------------------------------------------------------------------
  // state stage
  // ---------------------------------------------------------------------------
  logic [SpanW-1:0]       span_x_q, span_y_q, span_x_d, span_y_d;
  logic [StepsW-1:0]      steps_left_q, steps_left_d;
  logic signed [DevW-1:0] dev_q, dev_d;
  logic                   dir_x_q, dir_y_q, dir_x_d, dir_y_d;
  logic                   pend_q, pend_d;   // step total of a fresh load not yet summed

  logic [ProdW-1:0]  prod_x, prod_y;
  logic [SpanW-1:0]  scaled_x, scaled_y;
  logic [StepsW-1:0] cur_left;
  logic              out_ready, is_tick, emit, s1_adv, in_acc;
  logic              step_axis, step_dir;

  assign prod_x   = ProdW'(s1_mag_x_q) * ProdW'(spm_x_q);
  assign prod_y   = ProdW'(s1_mag_y_q) * ProdW'(spm_y_q);
  assign scaled_x = prod_x[ProdW-1:8];   // truncation toward zero on the magnitude
  assign scaled_y = prod_y[ProdW-1:8];

  // while pend_q is set the spans are summed here, so a tick right after a load needs no stored total
  assign cur_left = pend_q ? (StepsW'(span_x_q) + StepsW'(span_y_q)) : steps_left_q;

  assign out_ready = !m_axis_tvalid_o || m_axis_tready_i;
  assign is_tick   = s1_v_q && (s1_op_q == OP_TICK);
  assign emit      = is_tick && (cur_left != '0);
  assign s1_adv    = s1_v_q && (!emit || out_ready);

  assign s_axis_tready_o = !s1_v_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // zero deviation steps X, so an axis-aligned move still opens with one X step
  assign step_axis = (dev_q >= 0) ? AxisX : AxisY;
  assign step_dir  = (dev_q >= 0) ? dir_x_q : dir_y_q;

  always_comb begin
    span_x_d     = span_x_q;
    span_y_d     = span_y_q;
    dir_x_d      = dir_x_q;
    dir_y_d      = dir_y_q;
    steps_left_d = steps_left_q;
    dev_d        = dev_q;
    pend_d       = pend_q;
    if (s1_adv && (s1_op_q == OP_LOAD)) begin
      // a load drops whatever is left of the running move
      span_x_d = scaled_x;
      span_y_d = scaled_y;
      dir_x_d  = !s1_neg_x_q && (scaled_x != '0);
      dir_y_d  = !s1_neg_y_q && (scaled_y != '0);
      dev_d    = '0;
      pend_d   = 1'b1;
    end else begin
      if (pend_q) begin
        steps_left_d = cur_left;
        pend_d       = 1'b0;
      end
      if (s1_adv && emit) begin
        steps_left_d = cur_left - StepsW'(1);
        if (dev_q >= 0) begin
          dev_d = dev_q - DevW'(span_y_q);
        end else begin
          dev_d = dev_q + DevW'(span_x_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_x_q     <= '0;
      span_y_q     <= '0;
      dir_x_q      <= 1'b0;
      dir_y_q      <= 1'b0;
      steps_left_q <= '0;
      dev_q        <= '0;
      pend_q       <= 1'b0;
    end else begin
      span_x_q     <= span_x_d;
      span_y_q     <= span_y_d;
      dir_x_q      <= dir_x_d;
      dir_y_q      <= dir_y_d;
      steps_left_q <= steps_left_d;
      dev_q        <= dev_d;
      pend_q       <= pend_d;
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= op_e'(s_axis_tuser_i);
      s1_mag_x_q <= mag_x;
      s1_mag_y_q <= mag_y;
      s1_neg_x_q <= dx[DeltaW-1];
      s1_neg_y_q <= dy[DeltaW-1];
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic out_v_q, out_axis_q, out_dir_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv && emit) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_axis_q <= step_axis;
      out_dir_q  <= step_dir;
      out_last_q <= (cur_left == StepsW'(1));
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(OutDataW-2){1'b0}}, out_dir_q, out_axis_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- rtl/lsi_checker.sv -----
// port-level checks for the linear step interpolator, bound to the top level
`timescale 1ns / 1ps

module lsi_checker
  import lsi_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("output word changed while stalled");

  // with the output empty nothing can back up into the slave side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("slave side stalled with empty output");

  // with nothing taken in, the pipe drains as soon as the output is not stalled
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o && !(s_axis_tvalid_i && s_axis_tready_o)) ##1
      (!m_axis_tvalid_o || m_axis_tready_i) |=> !m_axis_tvalid_o)
    else $error("step word appeared with no word in flight");

  // the configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind linear_step_interpolator lsi_checker u_lsi_checker (.*);

// ----- tb/sv/lsi_step_checker.sv -----
// step predictor and scoreboard watching the interpolator's channels
`timescale 1ns / 1ps

module lsi_step_checker
  import lsi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_user_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OutDataW-1:0] out_data_i,
  input  logic                out_last_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic axis;
    logic dir;
    logic last;
  } step_t;

  step_t             step_q[$];
  step_t             got_step;
  step_t             want_step;
  logic [SpmW-1:0]   rate_x;
  logic [SpmW-1:0]   rate_y;
  longint unsigned   steps_to_go;
  longint unsigned   run_x;
  longint unsigned   run_y;
  longint            deviation;
  logic              heading_x;
  logic              heading_y;
  int                mismatches;

  // low COORD_WIDTH bits of a field as a signed value
  function automatic longint coord_value(input logic [FieldW-1:0] f);
    longint unsigned v;
    v = 64'(f) & ((64'd1 << COORD_WIDTH) - 64'd1);
    if (v[COORD_WIDTH-1]) return longint'(v) - (longint'(1) << COORD_WIDTH);
    return longint'(v);
  endfunction

  // |delta| * rate / 256, truncated; heading set only for a positive delta with a nonzero count
  function automatic longint unsigned scaled_run(input longint delta,
                                                 input logic [SpmW-1:0] rate,
                                                 output logic heading);
    longint unsigned mag;
    longint unsigned n;
    mag = (delta < 0) ? longint'(-delta) : longint'(delta);
    n = (mag * 64'(rate)) >> 8;
    heading = (delta > 0) && (n != 0);
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q.delete();
      rate_x       = SpmReset;
      rate_y       = SpmReset;
      steps_to_go  = 0;
      run_x        = 0;
      run_y        = 0;
      deviation    = 0;
      heading_x    = 1'b0;
      heading_y    = 1'b0;
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgXSpm) rate_x = cfg_data_i;
        else if (cfg_index_i == CfgYSpm) rate_y = cfg_data_i;
      end

      if (out_valid_i && out_ready_i) begin
        got_step.axis = out_data_i[0];
        got_step.dir  = out_data_i[1];
        got_step.last = out_last_i;
        if (step_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected step word: axis %0d dir %0d last %0d",
                     got_step.axis, got_step.dir, got_step.last);
          mismatches++;
        end else begin
          want_step = step_q.pop_front();
          if (got_step != want_step) begin
            if (mismatches < 10)
              $display({"step mismatch: expected axis %0d dir %0d last %0d, ",
                        "got axis %0d dir %0d last %0d"},
                       want_step.axis, want_step.dir, want_step.last,
                       got_step.axis, got_step.dir, got_step.last);
            mismatches++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (in_user_i == OP_LOAD) begin
          run_x = scaled_run(coord_value(in_data_i[2*FieldW +: FieldW]) -
                             coord_value(in_data_i[0 +: FieldW]), rate_x, heading_x);
          run_y = scaled_run(coord_value(in_data_i[3*FieldW +: FieldW]) -
                             coord_value(in_data_i[FieldW +: FieldW]), rate_y, heading_y);
          steps_to_go = run_x + run_y;
          deviation   = 0;
        end else if (steps_to_go != 0) begin
          if (deviation >= 0) begin
            want_step.axis = AxisX;
            want_step.dir  = heading_x;
            deviation      = deviation - longint'(run_y);
          end else begin
            want_step.axis = AxisY;
            want_step.dir  = heading_y;
            deviation      = deviation + longint'(run_x);
          end
          steps_to_go--;
          want_step.last = (steps_to_go == 0);
          step_q.push_back(want_step);
        end
      end

      pending_o    <= step_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top: clock, reset, stimulus and verdict for the step interpolator
`timescale 1ns / 1ps

module tb;
  import lsi_pkg::*;

  localparam int RandomItems = 1000;
  localparam int Phases      = 6;
  localparam int CycleLimit  = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;

  // slave side, driven here
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data = '0;   // start_x, start_y, end_x, end_y
  logic                in_user = OP_TICK;   // operation

  // master side, sunk here
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;   // step_axis, step_dir, zero fill
  logic                out_last;

  // configuration channel
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int                  fail_count;
  int                  pending;

  // idle percentages, changed by the stimulus as the run goes on
  int                  send_idle = 18;
  int                  recv_idle = 66;
  int                  items_done = 0;
  int                  cycle_count = 0;

  // steps-per-mm currently programmed, used only to size the moves
  int                  cur_rate_x = 80;
  int                  cur_rate_y = 80;

  always #1 clk_i = ~clk_i;

  linear_step_interpolator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tlast_o  (out_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  lsi_step_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .in_user_i    (in_user),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .out_last_i   (out_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver backpressure, random per cycle
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one word on the slave side; valid stays high afterwards so back-to-back
  // words never see valid dropped and raised in the same step
  task automatic send_word(input op_e op, input logic [FieldW-1:0] sx,
                           input logic [FieldW-1:0] sy, input logic [FieldW-1:0] ex,
                           input logic [FieldW-1:0] ey);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_user  <= op;
    in_data  <= {ey, ex, sy, sx};
    do @(posedge clk_i); while (!in_ready);
    items_done++;
  endtask

  // tick words carry random data in the unused coordinate fields
  task automatic send_tick();
    send_word(OP_TICK, FieldW'($urandom), FieldW'($urandom), FieldW'($urandom),
              FieldW'($urandom));
  endtask

  // a load followed by a number of ticks
  task automatic run_move(input int sx, input int sy, input int ex, input int ey,
                          input int ticks);
    send_word(OP_LOAD, FieldW'(sx), FieldW'(sy), FieldW'(ex), FieldW'(ey));
    repeat (ticks) send_tick();
  endtask

  // stop sending, then hold until every step has come out and the
  // pipeline has had time to settle after any trailing load or idle tick
  task automatic wait_quiet();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // register write; valid is lowered by the caller once all writes are done
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // reprogram both rates with the block idle; optionally hit an unused index
  task automatic program_rates(input int rx, input int ry, input bit stray);
    wait_quiet();
    write_reg(CfgXSpm, CfgDataW'(rx));
    write_reg(CfgYSpm, CfgDataW'(ry));
    if (stray) begin
      write_reg(CfgIdxW'($urandom_range(2, (1 << CfgIdxW) - 1)), CfgDataW'($urandom));
    end
    cfg_valid <= 1'b0;
    cur_rate_x = rx;
    cur_rate_y = ry;
  endtask

  // random delta sized so that the axis makes at most about 40 steps
  function automatic int pick_delta(input int rate);
    int span;
    int d;
    span = (rate == 0) ? 4096 : (40 * 256) / rate;
    if (span < 1) span = 1;
    d = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(0, span));
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  // start point far enough from the edges that start + delta still fits
  function automatic int pick_start();
    return int'($urandom_range(0, 32'h00FE_0000)) - 32'h007F_0000;
  endfunction

  // one burst of random stimulus: mostly complete moves, some cut short,
  // some wild loads, some stray ticks
  task automatic random_burst(input int done_random);
    int sel;
    int sx;
    int sy;
    int dx;
    int dy;
    longint total;
    int ticks;
    if (done_random < RandomItems / 3) begin
      send_idle = 18;
      recv_idle = 66;
    end else if (done_random < (2 * RandomItems) / 3) begin
      send_idle = 66;
      recv_idle = 18;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      sx = pick_start();
      sy = pick_start();
      dx = pick_delta(cur_rate_x);
      dy = pick_delta(cur_rate_y);
      total = ((longint'(dx < 0 ? -dx : dx) * cur_rate_x) >> 8) +
              ((longint'(dy < 0 ? -dy : dy) * cur_rate_y) >> 8);
      if ($urandom_range(0, 99) < 15) ticks = $urandom_range(0, int'(total));
      else ticks = int'(total) + $urandom_range(0, 3);
      run_move(sx, sy, sx + dx, sy + dy, ticks);
    end else if (sel < 90) begin
      run_move($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 5));
    end else begin
      repeat ($urandom_range(1, 4)) send_tick();
    end
  endtask

  initial begin
    int base;
    int rx;
    int ry;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, rates at their reset value of 80
    send_tick();                                       // idle tick right after reset
    run_move(0, 0, 16, 0, 6);                          // X only, one idle tick at the end
    run_move(0, 0, 0, -13, 4);                         // Y only backwards, first step still on X
    run_move(100, 100, 103, 90, 3);                    // X delta truncates to zero
    run_move(-8388608, 8388607, 8388607, -8388608, 2); // widest move, cut short
    run_move(0, 0, 10, -7, 5);                         // mixed directions, runs out
    run_move(-1, -1, -1, -1, 1);                       // zero-length move then idle tick
    base = items_done;

    // random phases, each with its own rates, extremes and the zero rate among them
    for (int phase = 0; phase < Phases; phase++) begin
      unique case (phase)
        0: begin rx = 1023; ry = 1; end
        1: begin rx = 1; ry = 1023; end
        2: begin rx = 1023; ry = 1023; end
        3: begin rx = $urandom_range(1, 1023); ry = $urandom_range(1, 1023); end
        4: begin rx = 0; ry = $urandom_range(1, 1023); end
        default: begin rx = $urandom_range(1, 1023); ry = $urandom_range(0, 1023); end
      endcase
      program_rates(rx, ry, phase == 3);
      while (items_done - base < ((phase + 1) * RandomItems) / Phases)
        random_burst(items_done - base);
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
